### design/ts_pkg.sv
// Shared types and codes for the software timer slot bank.
// Used by ts_cell, ts_ctrl and multi_slot_software_timer_bank.
package ts_pkg;

  // Collect reports at most this many slots per command
  localparam int MAX_RESULTS = 8;
  localparam int NRES_W      = 4;

  typedef enum logic [2:0] {
    MD_CREATE  = 3'd0,
    MD_START   = 3'd1,
    MD_PAUSE   = 3'd2,
    MD_STOP    = 3'd3,
    MD_DELETE  = 3'd4,
    MD_TICK    = 3'd5,
    MD_COLLECT = 3'd6,
    MD_DEL_ALL = 3'd7
  } ts_mode_t;

  typedef enum logic [2:0] {
    ST_DONE    = 3'd0,
    ST_CREATED = 3'd1,
    ST_NOSLOT  = 3'd2,
    ST_EXPIRED = 3'd3,
    ST_NONE    = 3'd4
  } ts_status_t;

  // Command token that walks down the row of slot cells
  typedef struct packed {
    logic              valid;
    ts_mode_t          mode;
    logic [2:0]        slot;
    logic [15:0]       period;
    logic [15:0]       delay;
    logic              found;      // create: a free slot was claimed
    logic [2:0]        fslot;      // create: claimed slot
    logic              pend;       // collect: an expiry is held back
    logic [2:0]        pend_slot;  // collect: held slot
    logic [NRES_W-1:0] nres;       // collect: slots reported so far
  } ts_tok_t;

  // Intermediate collect result released by a cell
  typedef struct packed {
    logic       valid;
    logic [2:0] slot;
  } ts_evt_t;

endpackage

### design/ts_cell.sv
// One timer slot: holds the slot state and applies the passing command token.
// Depends on ts_pkg.
module ts_cell #(
  parameter int SLOT_ID = 0
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            step,
  input  ts_pkg::ts_tok_t tok_i,
  output ts_pkg::ts_tok_t tok_o,
  output ts_pkg::ts_evt_t evt
);

  localparam logic [2:0] ID3   = 3'(SLOT_ID);
  localparam bit         REACH = (SLOT_ID < 8);

  logic        taken, taken_next;
  logic        active, active_next;
  logic        expired, expired_next;
  logic [15:0] delay, delay_next;
  logic [15:0] period, period_next;
  logic [15:0] count, count_next;
  ts_pkg::ts_tok_t tok_next;
  logic        hit;
  logic [16:0] cnt_inc;

  // Apply the command held in the token to this slot
  always_comb begin
    taken_next   = taken;
    active_next  = active;
    expired_next = expired;
    delay_next   = delay;
    period_next  = period;
    count_next   = count;
    tok_next     = tok_i;
    evt          = '0;
    hit          = REACH && (tok_i.slot == ID3);
    cnt_inc      = {1'b0, count} + 17'd1;
    if (tok_i.valid) begin
      unique case (tok_i.mode)
        ts_pkg::MD_CREATE: begin
          if (!tok_i.found && !taken) begin
            expired_next   = 1'b0;
            taken_next     = 1'b1;
            delay_next     = tok_i.delay;
            period_next    = tok_i.period;
            tok_next.found = 1'b1;
            tok_next.fslot = ID3;
          end
        end
        ts_pkg::MD_START: begin
          if (hit) active_next = 1'b1;
        end
        ts_pkg::MD_PAUSE: begin
          if (hit) active_next = 1'b0;
        end
        ts_pkg::MD_STOP: begin
          if (hit) begin
            active_next = 1'b0;
            count_next  = '0;
          end
        end
        ts_pkg::MD_DELETE: begin
          if (hit) begin
            active_next = 1'b0;
            count_next  = '0;
            taken_next  = 1'b0;
          end
        end
        ts_pkg::MD_TICK: begin
          // count the start delay down first, then count up to the period
          if (active) begin
            if (delay != 16'd0) begin
              delay_next = delay - 16'd1;
            end else if (cnt_inc >= {1'b0, period}) begin
              expired_next = 1'b1;
              count_next   = '0;
            end else begin
              count_next = cnt_inc[15:0];
            end
          end
        end
        ts_pkg::MD_COLLECT: begin
          // release the held expiry and hold this one, it may be the last
          if (expired && (tok_i.nres < ts_pkg::NRES_W'(ts_pkg::MAX_RESULTS))) begin
            expired_next       = 1'b0;
            evt.valid          = tok_i.pend;
            evt.slot           = tok_i.pend_slot;
            tok_next.pend      = 1'b1;
            tok_next.pend_slot = ID3;
            tok_next.nres      = tok_i.nres + ts_pkg::NRES_W'(1);
          end
        end
        ts_pkg::MD_DEL_ALL: begin
          active_next = 1'b0;
          count_next  = '0;
          taken_next  = 1'b0;
        end
      endcase
    end
  end

  // Hold state and hand the token to the next cell on each step
  always_ff @(posedge clk) begin
    if (rst) begin
      taken   <= 1'b0;
      active  <= 1'b0;
      expired <= 1'b0;
      delay   <= '0;
      period  <= '0;
      count   <= '0;
      tok_o   <= '0;
    end else if (step) begin
      taken   <= taken_next;
      active  <= active_next;
      expired <= expired_next;
      delay   <= delay_next;
      period  <= period_next;
      count   <= count_next;
      tok_o   <= tok_next;
    end
  end

endmodule

### design/ts_ctrl.sv
// Input word capture, step control and result register of the timer bank.
// Depends on ts_pkg.
module ts_ctrl #(
  parameter int SLOTS = 8
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  output logic            s_tready,
  input  logic [39:0]     s_tdata,
  input  logic [2:0]      s_tuser,
  output logic            m_tvalid,
  input  logic            m_tready,
  output logic [7:0]      m_tdata,
  output logic [2:0]      m_tuser,
  output logic            m_tlast,
  output logic            step,
  output ts_pkg::ts_tok_t tok0,
  input  ts_pkg::ts_tok_t tok_x,
  input  ts_pkg::ts_evt_t evts [SLOTS]
);

  logic               busy;
  logic               accept;
  logic [SLOTS-1:0]   ev_v;
  ts_pkg::ts_evt_t    ev;
  ts_pkg::ts_status_t fin_status;
  logic [2:0]         fin_slot;
  ts_pkg::ts_status_t res_status;
  logic [2:0]         res_slot;
  logic               res_last;

  // Advance the chain whenever the result register is free or being taken
  assign step     = !m_tvalid || m_tready;
  assign s_tready = !busy;
  assign accept   = s_tvalid && s_tready;
  assign m_tdata  = {5'b0, res_slot};
  assign m_tuser  = res_status;
  assign m_tlast  = res_last;

  // Gather the one cell result, if any, released this step
  always_comb begin
    ev = '0;
    for (int k = 0; k < SLOTS; k++) begin
      ev_v[k] = evts[k].valid;
      if (evts[k].valid) ev = evts[k];
    end
  end

  // Final result once the token leaves the last cell
  always_comb begin
    fin_status = ts_pkg::ST_DONE;
    fin_slot   = 3'd0;
    unique case (tok_x.mode)
      ts_pkg::MD_CREATE: begin
        fin_status = tok_x.found ? ts_pkg::ST_CREATED : ts_pkg::ST_NOSLOT;
        fin_slot   = tok_x.found ? tok_x.fslot : 3'd0;
      end
      ts_pkg::MD_COLLECT: begin
        fin_status = tok_x.pend ? ts_pkg::ST_EXPIRED : ts_pkg::ST_NONE;
        fin_slot   = tok_x.pend ? tok_x.pend_slot : 3'd0;
      end
      default: begin
        fin_status = ts_pkg::ST_DONE;
        fin_slot   = 3'd0;
      end
    endcase
  end

  // Capture the input word and track the command in flight
  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      tok0       <= '0;
    end else begin
      if (accept) begin
        busy           <= 1'b1;
        tok0.valid     <= 1'b1;
        tok0.mode      <= ts_pkg::ts_mode_t'(s_tuser);
        tok0.slot      <= s_tdata[2:0];
        tok0.period    <= s_tdata[18:3];
        tok0.delay     <= s_tdata[34:19];
        tok0.found     <= 1'b0;
        tok0.fslot     <= 3'd0;
        tok0.pend      <= 1'b0;
        tok0.pend_slot <= 3'd0;
        tok0.nres      <= '0;
      end else if (step) begin
        tok0.valid <= 1'b0;
        if (tok_x.valid) busy <= 1'b0;
      end
    end
  end

  // Load the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (step) begin
      m_tvalid <= tok_x.valid || ev.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      if (tok_x.valid) begin
        res_status <= fin_status;
        res_slot   <= fin_slot;
        res_last   <= 1'b1;
      end else begin
        res_status <= ts_pkg::ST_EXPIRED;
        res_slot   <= ev.slot;
        res_last   <= 1'b0;
      end
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> !s_tready)
    else $error("input taken again while a command is in flight");
  a_entry_busy: assert property (@(posedge clk) disable iff (rst)
    tok0.valid |-> busy)
    else $error("token at chain entry without a command in flight");
  a_exit_busy: assert property (@(posedge clk) disable iff (rst)
    tok_x.valid |-> busy)
    else $error("token at chain exit without a command in flight");
  a_one_event: assert property (@(posedge clk) disable iff (rst)
    $onehot0(ev_v))
    else $error("more than one cell released a result in one step");

endmodule

### design/multi_slot_software_timer_bank.sv
// Top level of the software timer slot bank: control stage and a row of slot cells.
// Depends on ts_pkg, ts_cell and ts_ctrl.
//
// Use: one command word enters on the s_ channel (tuser = mode, tdata = slot,
// period, start delay). The command token then walks the row of SLOTS cells,
// one cell per cycle while m_ is not stalled; each cell applies it to its own
// slot, so create takes the lowest free slot and collect visits expired slots
// in ascending order. Results leave on the m_ channel (tuser = status, tdata =
// slot, tlast marks the final result of a command). Collect gives one word per
// reported slot, at most eight, or one "nothing expired" word.
// Handshake: the final result is loaded into the result register when the token
// leaves the last cell; s_tready rises together with it, so a new word is taken
// only once the previous command is through the walk along the cell row.
// A stall on m_ (m_tvalid high, m_tready low) freezes the whole row, timers
// included, until the held word is taken; no word is lost.
// Reset (rst, synchronous) frees every slot, clears all counts, marks and
// run states, and empties the chain and the result register at once.
module multi_slot_software_timer_bank #(
  parameter int SLOTS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // slot[2:0], period[18:3], start_delay[34:19], zero[39:35]
  input  logic [2:0]  s_tuser,   // mode[2:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // slot_res[2:0], zero[7:3]
  output logic [2:0]  m_tuser,   // status[2:0]
  output logic        m_tlast    // last
);

  logic            step;
  ts_pkg::ts_tok_t chain [SLOTS+1];
  ts_pkg::ts_evt_t evts  [SLOTS];

  // Command capture and result register
  ts_ctrl #(
    .SLOTS(SLOTS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .step     (step),
    .tok0     (chain[0]),
    .tok_x    (chain[SLOTS]),
    .evts     (evts)
  );

  // Row of slot cells, token passed from each cell to the next
  for (genvar k = 0; k < SLOTS; k++) begin : g_cell
    ts_cell #(
      .SLOT_ID(k)
    ) u_cell (
      .clk   (clk),
      .rst   (rst),
      .step  (step),
      .tok_i (chain[k]),
      .tok_o (chain[k+1]),
      .evt   (evts[k])
    );
  end

endmodule
